// ===== hw/rtl/swmr_pkg.sv =====
`default_nettype none

package swmr_pkg;

  // store depth and sample width
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS    = 7;
  localparam int IDX_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_BITS   = $clog2(MAX_WINDOW + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [FILL_BITS-1:0]   fill_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // controls from the sequencer to the row of cells
  typedef struct packed {
    logic    shift;
    logic    start;
    sample_t data;
    idx_t    wlast;
  } chain_ctl_t;

  // index of the oldest cell in the window, zero length acts as one
  function automatic idx_t last_index(input len_t len);
    idx_t r;
    if (len == '0) begin
      r = '0;
    end else if (int'(len) > MAX_WINDOW) begin
      r = idx_t'(MAX_WINDOW - 1);
    end else begin
      r = idx_t'(len - 1'b1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swmr_cell.sv =====
`default_nettype none

module swmr_cell import swmr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  logic    seed,
  input  logic    tok_in,
  input  sample_t din,
  input  sample_t hi_in,
  input  sample_t lo_in,
  output sample_t val,
  output sample_t hi,
  output sample_t lo,
  output logic    tok
);

  sample_t cand;

  // value seen by the sweep, the incoming one in a shift cycle
  assign cand = shift ? din : val;

  // sweep token moves one cell toward the head each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= seed | tok_in;
    end
  end

  // sample storage and running max / min
  always_ff @(posedge clk) begin
    if (shift) begin
      val <= din;
    end
    if (seed) begin
      hi <= cand;
      lo <= cand;
    end else if (tok_in) begin
      hi <= (cand > hi_in) ? cand : hi_in;
      lo <= (cand < lo_in) ? cand : lo_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swmr_chain.sv =====
`default_nettype none

module swmr_chain import swmr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  output sample_t    hi0,
  output sample_t    lo0,
  output logic       done
);

  sample_t                val [MAX_WINDOW];
  sample_t                hi  [MAX_WINDOW];
  sample_t                lo  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  tok;
  logic [MAX_WINDOW-1:0]  seed;

  // sweep starts at the oldest cell of the window
  always_comb begin
    seed = '0;
    if (ctl.start) begin
      seed[ctl.wlast] = 1'b1;
    end
  end

  // row of cells, samples move up, the sweep moves down to cell 0
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    sample_t din_k;
    sample_t hi_in_k;
    sample_t lo_in_k;
    logic    tok_in_k;

    if (k == 0) begin : g_head
      assign din_k = ctl.data;
    end else begin : g_body
      assign din_k = val[k-1];
    end

    if (k == MAX_WINDOW - 1) begin : g_tail
      assign hi_in_k  = '0;
      assign lo_in_k  = '1;
      assign tok_in_k = 1'b0;
    end else begin : g_link
      assign hi_in_k  = hi[k+1];
      assign lo_in_k  = lo[k+1];
      assign tok_in_k = tok[k+1];
    end

    swmr_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (ctl.shift),
      .seed   (seed[k]),
      .tok_in (tok_in_k),
      .din    (din_k),
      .hi_in  (hi_in_k),
      .lo_in  (lo_in_k),
      .val    (val[k]),
      .hi     (hi[k]),
      .lo     (lo[k]),
      .tok    (tok[k])
    );
  end

  // window result lands in the head cell
  assign hi0  = hi[0];
  assign lo0  = lo[0];
  assign done = tok[0];

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_max_range.sv =====
// Sliding window range tracker.
// Sample channel: sample, last_sample with sample_valid / sample_ready.
// Result channel: max_range with result_valid / result_ready, one item per
// sequence, given on the item flagged by last_sample: the largest window max
// minus min of the sequence, or 0 if no full window occurred.
// Config channel: window_len with cfg_valid / cfg_ready, always ready; write
// it only between sequences. 0 acts as 1, values above 64 act as 64.
// Samples shift into a row of 64 cells, newest at cell 0. A sweep token
// starts at the oldest cell of the window and walks one cell a cycle toward
// cell 0, folding max and min as it goes. sample_ready stays low until the
// sweep ends, so no new sample is taken while an item is busy; an item that
// completes no window starts no sweep but still passes the sweep state.
// A result becomes valid, registered, as the block leaves the sweep state
// for a last sample, after its sweep if that sample completes a window.
// The output register holds a waiting result while the next sequence runs;
// a last sample that finishes while that result still waits holds the
// sweep until the result is taken.
// Reset clears the fill count, the best range and both channels, and sets
// window_len to 1. Cell contents are not cleared; only filled cells are read.
`default_nettype none

module sliding_window_max_range import swmr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  len_t    window_len,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  sample_t sample,
  input  logic    last_sample,
  output logic    result_valid,
  input  logic    result_ready,
  output sample_t max_range
);

  state_t     state;
  state_t     state_next;
  len_t       win_len;
  fill_t      fill;
  fill_t      fill_inc;
  sample_t    best;
  sample_t    best_new;
  sample_t    range_win;
  logic       win_ok;
  logic       win_ok_next;
  logic       last_q;
  logic       hold_q;
  logic       accept;
  logic       finishing;
  logic       emit_ok;
  logic       leave;
  idx_t       wlast;
  chain_ctl_t ctl;
  sample_t    hi0;
  sample_t    lo0;
  logic       done;

  assign cfg_ready = 1'b1;
  assign wlast     = last_index(win_len);
  assign accept    = sample_valid & sample_ready;

  // fill count after this item, and whether a full window is present
  assign fill_inc    = (fill == fill_t'(MAX_WINDOW)) ? fill : fill + 1'b1;
  assign win_ok_next = fill_inc > fill_t'(wlast);

  // range of the finished window and the best so far
  assign range_win = win_ok ? (hi0 - lo0) : '0;
  assign best_new  = (range_win > best) ? range_win : best;

  assign emit_ok   = ~last_q | ~result_valid | result_ready;
  assign finishing = (state == ST_SWEEP) & (~win_ok | done | hold_q);
  assign leave     = finishing & emit_ok;

  // row controls
  always_comb begin
    ctl.shift = accept;
    ctl.start = accept & win_ok_next;
    ctl.data  = sample;
    ctl.wlast = wlast;
  end

  swmr_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .hi0  (hi0),
    .lo0  (lo0),
    .done (done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_SWEEP;
      ST_SWEEP: if (leave)  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    sample_ready = 1'b0;
    unique case (state)
      ST_IDLE:  sample_ready = 1'b1;
      ST_SWEEP: sample_ready = 1'b0;
      default:  sample_ready = 1'b0;
    endcase
  end

  // control and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      win_len      <= len_t'(1);
      fill         <= '0;
      best         <= '0;
      win_ok       <= 1'b0;
      last_q       <= 1'b0;
      hold_q       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        win_len <= window_len;
      end
      if (accept) begin
        fill   <= fill_inc;
        win_ok <= win_ok_next;
        last_q <= last_sample;
        hold_q <= 1'b0;
      end
      if (finishing) begin
        hold_q <= ~emit_ok;
      end
      if (leave) begin
        if (last_q) begin
          fill <= '0;
          best <= '0;
        end else begin
          best <= best_new;
        end
      end
      if (leave && last_q) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (leave && last_q) begin
      max_range <= best_new;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/swmr_checker.sv =====
`default_nettype none

module swmr_checker import swmr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_ready,
  input logic    last_sample,
  input logic    result_valid,
  input logic    result_ready,
  input sample_t max_range
);

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && sample_ready)
    else $error("block not idle after reset");

  // a waiting result holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(max_range))
    else $error("stalled result changed");

  // the block is busy sweeping right after it takes an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("item taken while sweep in progress");

  // a result never appears in the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !$rose(result_valid))
    else $error("result too early");

  // a last item taken while no result is pending does not show its result at once
  a_last_not_early: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && last_sample && !result_valid |=> !result_valid)
    else $error("result shown before sweep of last item");

endmodule

bind sliding_window_max_range swmr_checker u_swmr_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import swmr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_WAIT = MAX_WINDOW + 8;
  localparam int HOLD_LEN    = 400;
  localparam int RANDOM_ITEMS = 420;
  localparam int TOTAL_ITEMS  = 520;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  len_t    window_len = '0;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample = '0;
  logic    last_sample = 1'b0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  sample_t max_range;

  // predicted state of the window tracker
  sample_t win_hist [MAX_WINDOW];
  int      hist_fill = 0;
  sample_t seq_best = '0;
  len_t    cur_len = len_t'(1);
  sample_t expected_ranges [$];

  // sender side controls
  bit gaps_allowed = 1'b1;
  bit send_gaps = 1'b0;
  int items_sent = 0;

  // receiver side controls, written by the test process with nonblocking
  bit ready_bursts = 1'b1;
  int hold_requests = 0;

  // receiver private state
  int holds_done = 0;
  int hold_left = 0;
  int stall_left = 0;

  int errors = 0;
  int cycles = 0;

  sliding_window_max_range dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_len   (window_len),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .last_sample  (last_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .max_range    (max_range)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // zero acts as one, anything past the store acts as the full store
  function automatic int eff_window(input len_t len);
    if (len == '0) return 1;
    if (int'(len) > MAX_WINDOW) return MAX_WINDOW;
    return int'(len);
  endfunction

  // shift one sample in, fold the window range, emit on the last sample
  task automatic fold_sample(input sample_t s, input logic last);
    int      w;
    sample_t hi;
    sample_t lo;
    sample_t span;
    w = eff_window(cur_len);
    for (int i = MAX_WINDOW - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
    win_hist[0] = s;
    if (hist_fill < MAX_WINDOW) hist_fill++;
    if (hist_fill >= w) begin
      hi = win_hist[0];
      lo = win_hist[0];
      for (int i = 1; i < w; i++) begin
        if (win_hist[i] > hi) hi = win_hist[i];
        if (win_hist[i] < lo) lo = win_hist[i];
      end
      span = hi - lo;
      if (span > seq_best) seq_best = span;
    end
    if (last) begin
      expected_ranges.insert(expected_ranges.size(), seq_best);
      hist_fill = 0;
      seq_best = '0;
    end
  endtask

  // offer one item and hold it until taken, then maybe idle a while
  task automatic send_item(input sample_t s, input logic last);
    int gap;
    sample <= s;
    last_sample <= last;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    fold_sample(s, last);
    items_sent++;
    if (send_gaps && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 6);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every result is in and the sweep has had time to finish
  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // window length write, only with the block idle
  task automatic write_window(input len_t v);
    drain();
    cfg_valid <= 1'b1;
    window_len <= v;
    do @(posedge clk); while (!cfg_ready);
    cur_len = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t pick_sample(input sample_t base);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return base + sample_t'($urandom_range(0, 63));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sequence(input int n);
    sample_t base;
    base = sample_t'($urandom);
    for (int i = 0; i < n; i++) send_item(pick_sample(base), i == n - 1);
  endtask

  // window of one right after reset, no write yet
  task automatic test_reset_window();
    send_gaps = 1'b0;
    send_item(16'h1234, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(16'hffff, 1'b1);
  endtask

  // zero length behaves as one
  task automatic test_zero_window();
    write_window('0);
    send_item(16'hffff, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0007, 1'b1);
  endtask

  // full-scale swings, lone sample, alternating bits
  task automatic test_extremes();
    write_window(len_t'(2));
    send_gaps = 1'b1;
    send_item(16'h0000, 1'b0);
    send_item(16'hffff, 1'b0);
    send_item(16'hffff, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'h0005, 1'b1);
    send_item(16'haaaa, 1'b0);
    send_item(16'h5555, 1'b1);
  endtask

  // lengths past the store, sequences too short for a window
  task automatic test_oversize_window();
    write_window(len_t'(127));
    send_gaps = 1'b0;
    for (int i = 0; i < 5; i++) send_item(sample_t'($urandom), i == 4);
    write_window(len_t'(MAX_WINDOW + 1));
    for (int i = 0; i < 3; i++) send_item(sample_t'($urandom), i == 2);
  endtask

  // receiver holds off while short sequences keep coming
  task automatic test_backpressure();
    write_window(len_t'(2));
    send_gaps = 1'b0;
    hold_requests <= hold_requests + 1;
    for (int k = 0; k < 12; k++) send_sequence(3);
  endtask

  // one window setting, a handful of sequences, some cut short
  task automatic run_random_phase();
    len_t len;
    int   w;
    int   n_seq;
    int   n;
    case ($urandom_range(15))
      0: len = '0;
      1: len = len_t'(MAX_WINDOW);
      2: len = len_t'($urandom_range(MAX_WINDOW + 1, 127));
      3: len = len_t'($urandom_range(17, MAX_WINDOW - 1));
      default: len = len_t'($urandom_range(1, 10));
    endcase
    write_window(len);
    w = eff_window(len);
    n_seq = (w > 16) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    for (int k = 0; k < n_seq; k++) begin
      if ($urandom_range(4) == 0) n = $urandom_range(1, (w > 1) ? w - 1 : 1);
      else n = w + $urandom_range(0, 12);
      send_gaps = gaps_allowed && ($urandom_range(2) != 0);
      send_sequence(n);
    end
  endtask

  task automatic test_random();
    while (items_sent < RANDOM_ITEMS) run_random_phase();
  endtask

  // closing stretch with both sides always ready
  task automatic test_no_idle();
    gaps_allowed = 1'b0;
    ready_bursts <= 1'b0;
    while (items_sent < TOTAL_ITEMS) run_random_phase();
  endtask

  // result check and receiver ready
  always @(posedge clk) begin : rx
    sample_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_ranges.size() == 0) begin
        errors++;
        $display("%0t: max_range expected no item actual %0h", $time, max_range);
      end else begin
        want = expected_ranges.pop_front();
        if (max_range !== want) begin
          errors++;
          $display("%0t: max_range expected %0h actual %0h", $time, want, max_range);
        end
      end
    end
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (hold_requests != holds_done) begin
      holds_done = hold_requests;
      hold_left = HOLD_LEN - 1;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (ready_bursts && $urandom_range(4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_zero_window();
    test_extremes();
    test_oversize_window();
    test_backpressure();
    test_random();
    test_no_idle();
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/swmr_pkg.sv
hw/rtl/swmr_cell.sv
hw/rtl/swmr_chain.sv
hw/rtl/sliding_window_max_range.sv
hw/rtl/swmr_checker.sv
tb/tb.sv
